FILE: hw/rtl/vfspwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfspwm_pkg;

    // Fixed field widths
    localparam int SPEED_W = 16;
    localparam int CNT_W   = 16;
    localparam int ADC_W   = 12;
    localparam int HIST_W  = 13;
    localparam int TAB_W   = 12;
    localparam int DUTY_W  = 12;
    localparam int PROD_W  = SPEED_W + 1 + TAB_W;
    localparam int ADDR_W  = 3;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_UPDATE_IVL  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_POLL_IVL    = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_RAMP_IVL    = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_CHECK_IVL   = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_SPEED_TGT   = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_SPEED_START = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_DC_TRIP     = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_FREQ_CONST  = 3'd7;

    // Input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Tick counter slots
    localparam int CNT_UPD   = 0;
    localparam int CNT_TAB   = 1;
    localparam int CNT_POLL  = 2;
    localparam int CNT_RAMP  = 3;
    localparam int CNT_CHECK = 4;
    localparam int NUM_CNT   = 5;

    localparam logic [DUTY_W-1:0]  DUTY_CENTER = 12'h6f1;
    localparam logic [HIST_W-1:0]  HIST_INIT   = 13'd2046;
    localparam logic [SPEED_W-1:0] Q15_MAX     = 16'h7fff;
    localparam logic [SPEED_W-1:0] INT_MAX     = 16'hffff;
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 12'hfff;
    localparam logic [ADC_W-1:0]   TRIP_INIT   = 12'hfff;
    localparam logic [SPEED_W-1:0] SPEED_INIT  = 16'd1;
    // Q15(11583 * 2046), the fixed average used at start
    localparam logic [HIST_W-1:0]  START_AVG   = 13'((11583 * 2046) >> 15);

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef struct packed {
        logic                start;
        logic                frac;
        logic [SPEED_W-1:0]  num;
        logic [SPEED_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [SPEED_W-1:0]  quot;
    } div_rsp_t;

    // Q30 sine of a first-quadrant angle in degrees, Taylor series, clamped
    function automatic logic [63:0] sine_q30(input int unsigned deg);
        logic [63:0]        r;
        logic [63:0]        r2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int unsigned        n;
        r    = (64'(deg) * PI_Q30) / 64'd180;
        r2   = (r * r) >> 30;
        term = r;
        sum  = 64'sd0;
        for (n = 1; n <= 17; n += 2) begin
            if (((n >> 1) & 1) == 0) begin
                sum = sum + $signed(term);
            end else begin
                sum = sum - $signed(term);
            end
            term = ((term * r2) >> 30) / 64'((n + 1) * (n + 2));
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if ($unsigned(sum) > ONE_Q30) begin
            sum = $signed(ONE_Q30);
        end
        return $unsigned(sum);
    endfunction

    // Scaled table entry for an angle in degrees
    function automatic logic signed [TAB_W-1:0] table_value(input int unsigned deg,
                                                            input int unsigned amp);
        int unsigned x;
        int unsigned a;
        logic        neg;
        logic [63:0] mag;
        x   = deg % 360;
        neg = 1'b0;
        if (x <= 90) begin
            a = x;
        end else if (x <= 180) begin
            a = 180 - x;
        end else if (x <= 270) begin
            a   = x - 180;
            neg = 1'b1;
        end else begin
            a   = 360 - x;
            neg = 1'b1;
        end
        mag = (64'(amp) * sine_q30(a) + 64'd16384) >> 30;
        return neg ? -$signed(TAB_W'(mag)) : $signed(TAB_W'(mag));
    endfunction

    // Centre plus floor-shifted Q15 product, saturated to the counter range
    function automatic logic [DUTY_W-1:0] make_duty(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] shf;
        logic signed [DUTY_W+2:0] d;
        shf = prod >>> 15;
        d   = (DUTY_W+3)'(shf) + $signed((DUTY_W+3)'(DUTY_CENTER));
        if (d < 0) begin
            return '0;
        end else if (d > $signed((DUTY_W+3)'(DUTY_MAX))) begin
            return DUTY_MAX;
        end
        return DUTY_W'(d);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vf_sine_pwm_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_func, s_vdc_upper, s_vdc_lower
// m_        m_valid/m_ready    m_duty_a, m_duty_b, m_pwm_on, m_relays_closed, m_fault
// cfg_      cfg_we (no wait)   cfg_addr, cfg_wdata
//
// One beat in, one beat out; s_ready is high only in idle.
// A tick that steps the table makes two multiplier passes. A start, and a tick with an
// update, use the shared divider for Q15 modulation and for the step period; each
// division is skipped when its quotient saturates. Synchronous active-low reset; no
// clearing pass.
// A finished beat waits in the output register; the next one stalls in FIN until it goes.
module vf_sine_pwm_controller_core #(
    parameter int TABLE_SAMPLES = 120,
    parameter int DEGREE_STEP   = 3,
    parameter int PWM_AMPLITUDE = 1777
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    // input beats
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire                                      s_func,
    input  wire [vfspwm_pkg::ADC_W-1:0]              s_vdc_upper,
    input  wire [vfspwm_pkg::ADC_W-1:0]              s_vdc_lower,
    // result beats
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output logic [vfspwm_pkg::DUTY_W-1:0]            m_duty_a,
    output logic [vfspwm_pkg::DUTY_W-1:0]            m_duty_b,
    output logic                                     m_pwm_on,
    output logic                                     m_relays_closed,
    output logic                                     m_fault,
    // configuration
    input  wire                                      cfg_we,
    input  wire [vfspwm_pkg::ADDR_W-1:0]             cfg_addr,
    input  wire [vfspwm_pkg::SPEED_W-1:0]            cfg_wdata
);

    localparam int SW    = vfspwm_pkg::SPEED_W;
    localparam int CW    = vfspwm_pkg::CNT_W;
    localparam int AW    = vfspwm_pkg::ADC_W;
    localparam int HW    = vfspwm_pkg::HIST_W;
    localparam int TW    = vfspwm_pkg::TAB_W;
    localparam int DW    = vfspwm_pkg::DUTY_W;
    localparam int PW    = vfspwm_pkg::PROD_W;
    localparam int NC    = vfspwm_pkg::NUM_CNT;
    localparam int POS_W = $clog2(TABLE_SAMPLES);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_UPD   = 12'b0000_0000_0010,
        ST_QDIV  = 12'b0000_0000_0100,
        ST_QWAIT = 12'b0000_0000_1000,
        ST_IDIV  = 12'b0000_0001_0000,
        ST_IWAIT = 12'b0000_0010_0000,
        ST_TAB   = 12'b0000_0100_0000,
        ST_MULA  = 12'b0000_1000_0000,
        ST_MULB  = 12'b0001_0000_0000,
        ST_DUTYB = 12'b0010_0000_0000,
        ST_MISC  = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    // sine and negated-cosine tables, built at elaboration
    logic signed [TW-1:0] sin_rom [TABLE_SAMPLES];
    logic signed [TW-1:0] cos_rom [TABLE_SAMPLES];

    for (genvar i = 0; i < TABLE_SAMPLES; i++) begin : g_rom
        assign sin_rom[i] = vfspwm_pkg::table_value(DEGREE_STEP * i, PWM_AMPLITUDE);
        assign cos_rom[i] = vfspwm_pkg::table_value(DEGREE_STEP * i + 270, PWM_AMPLITUDE);
    end

    // configuration registers
    logic [CW-1:0] upd_ivl_reg;
    logic [CW-1:0] poll_ivl_reg;
    logic [CW-1:0] ramp_ivl_reg;
    logic [CW-1:0] check_ivl_reg;
    logic [SW-1:0] speed_tgt_reg;
    logic [SW-1:0] speed_start_reg;
    logic [AW-1:0] trip_reg;
    logic [SW-1:0] freq_const_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_ivl_reg     <= '0;
            poll_ivl_reg    <= '0;
            ramp_ivl_reg    <= '0;
            check_ivl_reg   <= '0;
            speed_tgt_reg   <= '0;
            speed_start_reg <= vfspwm_pkg::SPEED_INIT;
            trip_reg        <= vfspwm_pkg::TRIP_INIT;
            freq_const_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                vfspwm_pkg::CFG_UPDATE_IVL:  upd_ivl_reg     <= cfg_wdata;
                vfspwm_pkg::CFG_POLL_IVL:    poll_ivl_reg    <= cfg_wdata;
                vfspwm_pkg::CFG_RAMP_IVL:    ramp_ivl_reg    <= cfg_wdata;
                vfspwm_pkg::CFG_CHECK_IVL:   check_ivl_reg   <= cfg_wdata;
                vfspwm_pkg::CFG_SPEED_TGT:   speed_tgt_reg   <= cfg_wdata;
                vfspwm_pkg::CFG_SPEED_START: speed_start_reg <= cfg_wdata;
                vfspwm_pkg::CFG_DC_TRIP:     trip_reg        <= cfg_wdata[AW-1:0];
                vfspwm_pkg::CFG_FREQ_CONST:  freq_const_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // controller state
    state_t          state_reg,  state_next;
    logic [CW-1:0]   cnt_reg    [NC];
    logic [CW-1:0]   cnt_next   [NC];
    logic [HW-1:0]   hist_reg   [4];
    logic [HW-1:0]   hist_next  [4];
    logic [1:0]      slot_reg,   slot_next;
    logic [AW-1:0]   half_a_reg, half_a_next;
    logic [AW-1:0]   half_b_reg, half_b_next;
    logic [AW-1:0]   in_a_reg,   in_a_next;
    logic [AW-1:0]   in_b_reg,   in_b_next;
    logic [SW-1:0]   speed_reg,  speed_next;
    logic [SW-1:0]   mod_reg,    mod_next;
    logic [SW-1:0]   step_reg,   step_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [DW-1:0]   duty_a_reg, duty_a_next;
    logic [DW-1:0]   duty_b_reg, duty_b_next;
    logic            pwm_reg,    pwm_next;
    logic            relay_reg,  relay_next;
    logic            fault_reg,  fault_next;
    logic            start_reg,  start_next;
    logic signed [PW-1:0] prod_reg, prod_next;

    // result register
    logic            m_valid_reg, m_valid_next;
    logic [DW-1:0]   o_duty_a_reg, o_duty_a_next;
    logic [DW-1:0]   o_duty_b_reg, o_duty_b_next;
    logic            o_pwm_reg,    o_pwm_next;
    logic            o_relay_reg,  o_relay_next;
    logic            o_fault_reg,  o_fault_next;

    // shared units
    vfspwm_pkg::div_req_t div_req;
    vfspwm_pkg::div_rsp_t div_rsp;

    vfspwm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic signed [SW:0]    mul_a;
    logic signed [TW-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;

    assign mul_a = $signed({1'b0, mod_reg});
    assign mul_b = (state_reg == ST_MULA) ? sin_rom[pos_reg] : cos_rom[pos_reg];
    assign mul_p = mul_a * mul_b;

    logic [HW+1:0] hist_sum;
    logic [HW-1:0] avg;
    logic [SW-1:0] q_den;
    logic [SW-1:0] ramp_inc;
    logic          accept;

    assign hist_sum = (HW+2)'(hist_reg[0]) + (HW+2)'(hist_reg[1])
                    + (HW+2)'(hist_reg[2]) + (HW+2)'(hist_reg[3]);
    assign avg      = hist_sum[HW+1:2];
    assign q_den    = SW'(start_reg ? vfspwm_pkg::START_AVG : avg);
    assign ramp_inc = speed_reg + SW'(1);
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hist_next     = hist_reg;
        slot_next     = slot_reg;
        half_a_next   = half_a_reg;
        half_b_next   = half_b_reg;
        in_a_next     = in_a_reg;
        in_b_next     = in_b_reg;
        speed_next    = speed_reg;
        mod_next      = mod_reg;
        step_next     = step_reg;
        pos_next      = pos_reg;
        duty_a_next   = duty_a_reg;
        duty_b_next   = duty_b_reg;
        pwm_next      = pwm_reg;
        relay_next    = relay_reg;
        fault_next    = fault_reg;
        start_next    = start_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_duty_a_next = o_duty_a_reg;
        o_duty_b_next = o_duty_b_reg;
        o_pwm_next    = o_pwm_reg;
        o_relay_next  = o_relay_reg;
        o_fault_next  = o_fault_reg;
        div_req       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    in_a_next  = s_vdc_upper;
                    in_b_next  = s_vdc_lower;
                    start_next = (s_func == vfspwm_pkg::FUNC_START);
                    if (s_func == vfspwm_pkg::FUNC_START) begin
                        for (int k = 0; k < NC; k++) begin
                            cnt_next[k] = '0;
                        end
                        pos_next    = '0;
                        speed_next  = speed_start_reg;
                        duty_a_next = vfspwm_pkg::DUTY_CENTER;
                        duty_b_next = vfspwm_pkg::DUTY_CENTER;
                        pwm_next    = 1'b1;
                        relay_next  = 1'b1;
                        state_next  = ST_QDIV;
                    end else begin
                        for (int k = 0; k < NC; k++) begin
                            cnt_next[k] = cnt_reg[k] + CW'(1);
                        end
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                // when the update count passes its interval, latch the halves and push their sum into the history
                if (cnt_reg[vfspwm_pkg::CNT_UPD] > upd_ivl_reg) begin
                    half_a_next         = in_a_reg;
                    half_b_next         = in_b_reg;
                    hist_next[slot_reg] = HW'(in_a_reg) + HW'(in_b_reg);
                    slot_next           = slot_reg + 2'd1;
                    cnt_next[vfspwm_pkg::CNT_UPD] = '0;
                    state_next          = ST_QDIV;
                end else begin
                    state_next = ST_TAB;
                end
            end
            ST_QDIV: begin
                // modulation = Q15(speed / average), saturating
                if (q_den == '0 || speed_reg >= q_den) begin
                    mod_next   = vfspwm_pkg::Q15_MAX;
                    state_next = ST_IDIV;
                end else begin
                    div_req.start = 1'b1;
                    div_req.frac  = 1'b1;
                    div_req.num   = speed_reg;
                    div_req.den   = q_den;
                    state_next    = ST_QWAIT;
                end
            end
            ST_QWAIT: begin
                if (div_rsp.done) begin
                    mod_next   = div_rsp.quot;
                    state_next = ST_IDIV;
                end
            end
            ST_IDIV: begin
                // step period = freq_constant / speed
                if (speed_reg == '0) begin
                    step_next  = vfspwm_pkg::INT_MAX;
                    state_next = start_reg ? ST_FIN : ST_TAB;
                end else begin
                    div_req.start = 1'b1;
                    div_req.frac  = 1'b0;
                    div_req.num   = freq_const_reg;
                    div_req.den   = speed_reg;
                    state_next    = ST_IWAIT;
                end
            end
            ST_IWAIT: begin
                if (div_rsp.done) begin
                    step_next  = div_rsp.quot;
                    state_next = start_reg ? ST_FIN : ST_TAB;
                end
            end
            ST_TAB: begin
                state_next = (cnt_reg[vfspwm_pkg::CNT_TAB] > step_reg) ? ST_MULA : ST_MISC;
            end
            ST_MULA: begin
                prod_next  = mul_p;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                duty_a_next = vfspwm_pkg::make_duty(prod_reg);
                prod_next   = mul_p;
                state_next  = ST_DUTYB;
            end
            ST_DUTYB: begin
                duty_b_next = vfspwm_pkg::make_duty(prod_reg);
                pos_next    = (pos_reg == POS_W'(TABLE_SAMPLES - 1)) ? '0
                                                                      : pos_reg + POS_W'(1);
                cnt_next[vfspwm_pkg::CNT_TAB] = '0;
                state_next  = ST_MISC;
            end
            ST_MISC: begin
                // poll sees the fault as it stood before this tick's check
                if (cnt_reg[vfspwm_pkg::CNT_POLL] > poll_ivl_reg) begin
                    if (fault_reg) begin
                        pwm_next   = 1'b0;
                        relay_next = 1'b0;
                    end
                    cnt_next[vfspwm_pkg::CNT_POLL] = '0;
                end
                if (cnt_reg[vfspwm_pkg::CNT_RAMP] > ramp_ivl_reg) begin
                    speed_next = (ramp_inc >= speed_tgt_reg) ? speed_tgt_reg : ramp_inc;
                    cnt_next[vfspwm_pkg::CNT_RAMP] = '0;
                end
                if (cnt_reg[vfspwm_pkg::CNT_CHECK] > check_ivl_reg) begin
                    if (half_a_reg > trip_reg || half_b_reg > trip_reg) begin
                        fault_next = 1'b1;
                    end
                    cnt_next[vfspwm_pkg::CNT_CHECK] = '0;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    o_duty_a_next = duty_a_reg;
                    o_duty_b_next = duty_b_reg;
                    o_pwm_next    = pwm_reg;
                    o_relay_next  = relay_reg;
                    o_fault_next  = fault_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        in_a_reg     <= in_a_next;
        in_b_reg     <= in_b_next;
        prod_reg     <= prod_next;
        o_duty_a_reg <= o_duty_a_next;
        o_duty_b_reg <= o_duty_b_next;
        o_pwm_reg    <= o_pwm_next;
        o_relay_reg  <= o_relay_next;
        o_fault_reg  <= o_fault_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            for (int k = 0; k < NC; k++) begin
                cnt_reg[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                hist_reg[k] <= vfspwm_pkg::HIST_INIT;
            end
            slot_reg    <= '0;
            half_a_reg  <= '0;
            half_b_reg  <= '0;
            speed_reg   <= '0;
            mod_reg     <= '0;
            step_reg    <= '0;
            pos_reg     <= '0;
            duty_a_reg  <= DW'(PWM_AMPLITUDE);
            duty_b_reg  <= DW'(PWM_AMPLITUDE);
            pwm_reg     <= 1'b0;
            relay_reg   <= 1'b0;
            fault_reg   <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            hist_reg    <= hist_next;
            slot_reg    <= slot_next;
            half_a_reg  <= half_a_next;
            half_b_reg  <= half_b_next;
            speed_reg   <= speed_next;
            mod_reg     <= mod_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            duty_a_reg  <= duty_a_next;
            duty_b_reg  <= duty_b_next;
            pwm_reg     <= pwm_next;
            relay_reg   <= relay_next;
            fault_reg   <= fault_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_duty_a        = o_duty_a_reg;
    assign m_duty_b        = o_duty_b_reg;
    assign m_pwm_on        = o_pwm_reg;
    assign m_relays_closed = o_relay_reg;
    assign m_fault         = o_fault_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vfspwm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Integer mode: num / den over 16 steps.
// Fraction mode: (num << 15) / den over 15 steps, caller keeps num < den.
module vfspwm_div (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  vfspwm_pkg::div_req_t     req,
    output vfspwm_pkg::div_rsp_t     rsp
);

    localparam int W = vfspwm_pkg::SPEED_W;

    logic [W-1:0]   rem_reg,  rem_next;
    logic [W-1:0]   quo_reg,  quo_next;
    logic [W-1:0]   den_reg,  den_next;
    logic [4:0]     step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    logic [W:0]     shifted;
    logic [W+1:0]   diff;
    logic           take;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign take    = ~diff[W+1];

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.frac ? req.num : '0;
            quo_next  = req.frac ? '0 : req.num;
            den_next  = req.den;
            step_next = req.frac ? 5'd15 : 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = take ? W'(diff) : W'(shifted);
            quo_next  = {quo_reg[W-2:0], take};
            step_next = step_reg - 5'd1;
            if (step_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

`default_nettype wire
